FILE: rtl/btp_pkg.sv
// ============================================================================
// btp_pkg
// Shared types and constants for the bencode token parser.
// ============================================================================
`default_nettype none

package btp_pkg;

    // parser modes, one-hot
    typedef enum logic [3:0] {
        MODE_TOKEN = 4'b0001,
        MODE_INT   = 4'b0010,
        MODE_LEN   = 4'b0100,
        MODE_STR   = 4'b1000
    } t_mode;

    // token kinds
    localparam logic [2:0] TK_INT  = 3'd0;
    localparam logic [2:0] TK_HDR  = 3'd1;
    localparam logic [2:0] TK_BYTE = 3'd2;
    localparam logic [2:0] TK_LIST = 3'd3;
    localparam logic [2:0] TK_DICT = 3'd4;
    localparam logic [2:0] TK_END  = 3'd5;
    localparam logic [2:0] TK_ERR  = 3'd6;

    // error codes
    localparam logic [2:0] ERR_UNEXP = 3'd0;
    localparam logic [2:0] ERR_DEEP  = 3'd1;
    localparam logic [2:0] ERR_STRAY = 3'd2;
    localparam logic [2:0] ERR_OVF   = 3'd3;
    localparam logic [2:0] ERR_NONE  = 3'd4;

    // stream characters
    localparam logic [7:0] CH_E     = 8'h65;  // 'e'
    localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [7:0] CH_L     = 8'h6C;  // 'l'
    localparam logic [7:0] CH_I     = 8'h69;  // 'i'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_D     = 8'h64;  // 'd'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'

    // integer limits, in the width of acc*10+d
    localparam logic [67:0] INT_LIM_POS = 68'h0_7FFF_FFFF_FFFF_FFFF;
    localparam logic [67:0] INT_LIM_NEG = 68'h0_8000_0000_0000_0000;

    // one result item
    typedef struct packed {
        logic [2:0]  token_kind;
        logic [63:0] number;
        logic [7:0]  data_byte;
        logic        final_byte;
        logic [5:0]  nest_level;
        logic        is_dict;
        logic [2:0]  error_code;
    } t_result;

    // nesting stack command and status
    typedef struct packed {
        logic push;
        logic pop;
        logic kind;   // 1 = dictionary
    } t_stk_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic top_kind;
    } t_stk_stat;

endpackage

`default_nettype wire

FILE: rtl/btp_stack.sv
// ============================================================================
// btp_stack
// Container-kind stack with a registered top and a prefetched second entry.
// ============================================================================
`default_nettype none

module btp_stack
    import btp_pkg::*;
#(
    parameter int MAX_DEPTH = 32,
    parameter int DEPTH_W   = $clog2(MAX_DEPTH + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_stk_cmd           i_cmd,
    output t_stk_stat               o_stat,
    output logic [DEPTH_W-1:0]      o_depth,
    output logic [DEPTH_W-1:0]      o_depth_next
);

    localparam int ADDR_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    logic               r_kinds [MAX_DEPTH];
    logic [DEPTH_W-1:0] r_depth;
    logic [DEPTH_W-1:0] n_depth;
    logic               r_top;
    logic               n_top;
    logic               r_below;     // entry under the top, prefetched
    logic [DEPTH_W-1:0] rd_full;
    logic [ADDR_W-1:0]  rd_addr;

    always_comb begin
        n_depth = r_depth;
        n_top   = r_top;
        if (i_cmd.push) begin
            n_depth = r_depth + 1'b1;
            n_top   = i_cmd.kind;
        end else if (i_cmd.pop) begin
            n_depth = r_depth - 1'b1;
            n_top   = r_below;
        end
        rd_full = (n_depth >= DEPTH_W'(2)) ? (n_depth - DEPTH_W'(2)) : '0;
        rd_addr = rd_full[ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else begin
            r_depth <= n_depth;
        end
    end

    // write old depth, read new depth - 2 (min 0): differ but on a push to empty
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_kinds[r_depth[ADDR_W-1:0]] <= i_cmd.kind;
        end
        r_below <= r_kinds[rd_addr];
        r_top   <= n_top;
    end

    assign o_stat.full     = (r_depth == DEPTH_W'(MAX_DEPTH));
    assign o_stat.empty    = (r_depth == '0);
    assign o_stat.top_kind = r_top;
    assign o_depth         = r_depth;
    assign o_depth_next    = n_depth;

endmodule

`default_nettype wire

FILE: rtl/btp_obuf.sv
// ============================================================================
// btp_obuf
// Result register with a skid stage; accepts while the skid stage is empty.
// ============================================================================
`default_nettype none

module btp_obuf
    import btp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_result i_res,
    output logic         o_ready,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_res
);

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && !i_ready) begin
            if (i_valid) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_valid && !i_ready) begin
            if (i_valid) begin
                r_skid <= i_res;
            end
        end else if (r_skid_valid) begin
            r_out <= r_skid;
        end else if (i_valid) begin
            r_out <= i_res;
        end
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

`default_nettype wire

FILE: rtl/bencode_token_parser_top.sv
// ============================================================================
// bencode_token_parser_top
// Bencode tokenizer: one stream byte in, at most one token item out.
// ============================================================================
// The block takes one byte per cycle when not stalled and emits zero or one
// token item per byte: integer values, string headers with their length,
// string payload bytes (tlast on the last byte of a string), list/dict
// starts and container ends, plus error items (unexpected byte, nesting too
// deep, stray end, number overflow). After an error it returns to token mode
// and keeps going with the next byte. Each byte is decoded by logic between
// the parser state registers and the result register; the critical path is
// the acc*10+d add and its range compare. Throughput is one byte per cycle
// while the input is not stalled; results are registered. A two-entry result
// buffer decouples the sides, so input stalls only once two results are
// waiting on the consumer. Nesting kinds live in a small memory with the top
// entry held in a register and the next one prefetched, no clearing pass.
`default_nettype none

module bencode_token_parser_top
    import btp_pkg::*;
#(
    parameter int MAX_DEPTH = 32,
    parameter int LEN_BITS  = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] in_byte
    // token stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [79:0]      o_m_tdata,   // [63:0] number, [71:64] data_byte,
                                          // [77:72] nest_level, [79:78] zero
    output logic [7:0]       o_m_tuser,   // [2:0] token_kind, [3] is_dict,
                                          // [6:4] error_code, [7] zero
    output logic             o_m_tlast    // final_byte
);

    localparam int          DEPTH_W   = $clog2(MAX_DEPTH + 1);
    localparam logic [67:0] LEN_LIMIT = (68'd1 << LEN_BITS) - 68'd1;

    // parser state
    t_mode               r_mode, n_mode;
    logic [63:0]         r_acc, n_acc;
    logic                r_minus, n_minus;
    logic                r_digit, n_digit;
    logic [LEN_BITS-1:0] r_rem, n_rem;

    logic        s_acc;
    logic [7:0]  b;
    logic        is_digit;
    logic [3:0]  d;
    logic [67:0] acc_w;
    logic [67:0] sum;
    logic        int_fits;
    logic        len_fits;

    logic        emit;
    logic        fail;
    logic [2:0]  fail_code;
    t_result     res;
    t_result     res_nl;
    t_stk_cmd    cmd_raw;
    t_stk_cmd    stk_cmd;
    t_stk_stat   stk_stat;
    logic [DEPTH_W-1:0] depth;
    logic [DEPTH_W-1:0] depth_next;
    logic [DEPTH_W+5:0] depth_ext;
    logic        obuf_ready;
    t_result     out_res;

    assign s_acc      = i_s_tvalid && obuf_ready;
    assign o_s_tready = obuf_ready;
    assign b          = i_s_tdata;
    assign is_digit   = (b >= CH_ZERO) && (b <= CH_NINE);
    assign d          = is_digit ? b[3:0] : 4'd0;

    // acc*10 + d, wide enough that it cannot wrap
    assign acc_w    = {4'd0, r_acc};
    assign sum      = (acc_w << 3) + (acc_w << 1) + {64'd0, d};
    assign int_fits = (sum <= (r_minus ? INT_LIM_NEG : INT_LIM_POS));
    assign len_fits = (sum <= LEN_LIMIT);

    always_comb begin
        n_mode    = r_mode;
        n_acc     = r_acc;
        n_minus   = r_minus;
        n_digit   = r_digit;
        n_rem     = r_rem;
        emit      = 1'b0;
        fail      = 1'b0;
        fail_code = ERR_UNEXP;
        cmd_raw   = '0;
        res       = '0;
        res.error_code = ERR_NONE;

        unique case (r_mode)
            MODE_INT: begin
                if (b == CH_MINUS && !r_minus && !r_digit) begin
                    n_minus = 1'b1;
                end else if (is_digit) begin
                    if (!int_fits) begin
                        fail      = 1'b1;
                        fail_code = ERR_OVF;
                    end else begin
                        n_acc   = sum[63:0];
                        n_digit = 1'b1;
                    end
                end else if (b == CH_E && r_digit) begin
                    emit           = 1'b1;
                    res.token_kind = TK_INT;
                    res.number     = r_minus ? (~r_acc + 64'd1) : r_acc;
                    n_mode         = MODE_TOKEN;
                    n_acc          = '0;
                    n_minus        = 1'b0;
                    n_digit        = 1'b0;
                end else begin
                    fail = 1'b1;
                end
            end
            MODE_LEN: begin
                if (is_digit) begin
                    if (!len_fits) begin
                        fail      = 1'b1;
                        fail_code = ERR_OVF;
                    end else begin
                        n_acc = sum[63:0];
                    end
                end else if (b == CH_COLON) begin
                    emit           = 1'b1;
                    res.token_kind = TK_HDR;
                    res.number     = r_acc;
                    n_acc          = '0;
                    n_digit        = 1'b0;
                    n_rem          = r_acc[LEN_BITS-1:0];
                    n_mode         = (r_acc == '0) ? MODE_TOKEN : MODE_STR;
                end else begin
                    fail = 1'b1;
                end
            end
            MODE_STR: begin
                emit           = 1'b1;
                res.token_kind = TK_BYTE;
                res.data_byte  = b;
                n_rem          = (r_rem == '0) ? '0 : (r_rem - 1'b1);
                res.final_byte = (r_rem <= LEN_BITS'(1));
                if (res.final_byte) begin
                    n_mode = MODE_TOKEN;
                end
            end
            MODE_TOKEN: begin
                if (b == CH_I) begin
                    n_mode  = MODE_INT;
                    n_acc   = '0;
                    n_minus = 1'b0;
                    n_digit = 1'b0;
                end else if (is_digit) begin
                    n_mode  = MODE_LEN;
                    n_acc   = {60'd0, d};
                    n_digit = 1'b1;
                end else if (b == CH_L || b == CH_D) begin
                    if (stk_stat.full) begin
                        fail      = 1'b1;
                        fail_code = ERR_DEEP;
                    end else begin
                        emit           = 1'b1;
                        cmd_raw.push   = 1'b1;
                        cmd_raw.kind   = (b == CH_D);
                        res.is_dict    = (b == CH_D);
                        res.token_kind = (b == CH_D) ? TK_DICT : TK_LIST;
                    end
                end else if (b == CH_E) begin
                    if (stk_stat.empty) begin
                        fail      = 1'b1;
                        fail_code = ERR_STRAY;
                    end else begin
                        emit           = 1'b1;
                        cmd_raw.pop    = 1'b1;
                        res.is_dict    = stk_stat.top_kind;
                        res.token_kind = TK_END;
                    end
                end else begin
                    fail = 1'b1;
                end
            end
            default: begin
                n_mode = MODE_TOKEN;
            end
        endcase

        // any error: back to token mode, integer scratch cleared
        if (fail) begin
            emit           = 1'b1;
            res            = '0;
            res.token_kind = TK_ERR;
            res.error_code = fail_code;
            n_mode         = MODE_TOKEN;
            n_acc          = '0;
            n_minus        = 1'b0;
            n_digit        = 1'b0;
        end
    end

    // depth after this item goes into the result
    always_comb begin
        depth_ext         = {6'd0, depth_next};
        res_nl            = res;
        res_nl.nest_level = depth_ext[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_TOKEN;
            r_acc   <= '0;
            r_minus <= 1'b0;
            r_digit <= 1'b0;
            r_rem   <= '0;
        end else if (s_acc) begin
            r_mode  <= n_mode;
            r_acc   <= n_acc;
            r_minus <= n_minus;
            r_digit <= n_digit;
            r_rem   <= n_rem;
        end
    end

    // stack only moves on an accepted byte
    always_comb begin
        stk_cmd      = cmd_raw;
        stk_cmd.push = cmd_raw.push && s_acc;
        stk_cmd.pop  = cmd_raw.pop && s_acc;
    end

    btp_stack #(
        .MAX_DEPTH (MAX_DEPTH),
        .DEPTH_W   (DEPTH_W)
    ) u_stack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (stk_cmd),
        .o_stat       (stk_stat),
        .o_depth      (depth),
        .o_depth_next (depth_next)
    );

    btp_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_acc && emit),
        .i_res   (res_nl),
        .o_ready (obuf_ready),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (out_res)
    );

    assign o_m_tdata = {2'b00, out_res.nest_level, out_res.data_byte, out_res.number};
    assign o_m_tuser = {1'b0, out_res.error_code, out_res.is_dict, out_res.token_kind};
    assign o_m_tlast = out_res.final_byte;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_str_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_STR) |-> (r_rem != '0))
        else $error("string mode with no bytes left");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        depth <= DEPTH_W'(MAX_DEPTH))
        else $error("nesting depth beyond limit");

    a_minus_int_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_minus |-> (r_mode == MODE_INT))
        else $error("minus flag outside integer mode");

    a_push_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && r_mode == MODE_TOKEN && (b == CH_L || b == CH_D) && !stk_stat.full)
        |=> (depth == DEPTH_W'($past(depth) + 1'b1)))
        else $error("container start did not raise depth");

endmodule

`default_nettype wire
